// ===== rtl/csp_pkg.sv =====
// Shared constants for the cardinal spline evaluator.
// Field widths, tension reset value and stream bus widths.
// No dependencies.
package csp_pkg;

    // input and result field widths
    localparam int T_W       = 17;   // t_param, unsigned Q1.16
    localparam int TENSION_W = 16;   // tension, unsigned Q2.14
    localparam int POINT_W   = 32;   // control values and curve value, signed Q16.16

    // default value width and tension after reset (0.5, Catmull-Rom)
    localparam int VALUE_WIDTH_DEF = 32;
    localparam logic [TENSION_W-1:0] TENSION_RESET = 16'd8192;

    // stream bus widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = T_W + 4 * POINT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = POINT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== rtl/csp_horner_step.sv =====
// One Horner step of the spline polynomial: r' = round16(r * t) + add.
// Two register stages, multiply then round and add; valid travels along.
// Depends on csp_pkg.
module csp_horner_step
    import csp_pkg::*;
#(
    parameter int RW = 42
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [RW-1:0] i_r,
    input  logic [T_W-1:0]       i_t,
    input  logic signed [RW-1:0] i_add,
    output logic                 o_vld,
    output logic signed [RW-1:0] o_r,
    output logic [T_W-1:0]       o_t
);

    localparam int PW = RW + T_W + 1;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(32'd32768);

    logic                 r_a_vld;
    logic signed [PW-1:0] r_a_prod;
    logic signed [RW-1:0] r_a_add;
    logic [T_W-1:0]       r_a_t;
    logic                 r_b_vld;
    logic signed [RW-1:0] r_b_r;
    logic [T_W-1:0]       r_b_t;

    logic signed [PW-1:0] n_sum;
    logic signed [RW-1:0] n_res;

    // stage A: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
        if (i_en) begin
            r_a_prod <= i_r * $signed({1'b0, i_t});
            r_a_add  <= i_add;
            r_a_t    <= i_t;
        end
    end

    // round to nearest (half up), floor shift by 16, then add
    always_comb begin
        n_sum = r_a_prod + ROUND_HALF;
        n_res = $signed(n_sum[RW+15:16]) + r_a_add;
    end

    // stage B: result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_r <= n_res;
            r_b_t <= r_a_t;
        end
    end

    assign o_vld = r_b_vld;
    assign o_r   = r_b_r;
    assign o_t   = r_b_t;

endmodule

// ===== rtl/cardinal_spline_evaluator.sv =====
// Ten register stages lie between item accepted and result available
//   (point differences, tension products, coefficients, three two-stage Horner steps,
//   output register).
// Throughput: one item per cycle while the skid stage is free; no multiplier is shared.
// A one-item skid stage behind the output register keeps o_s_tready registered.
// Reset (synchronous, active low) empties the pipeline and sets tension to 0.5.
module cardinal_spline_evaluator
    import csp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: tension, unsigned Q2.14
    input  logic                   i_cfg_wr_en,
    input  logic [TENSION_W-1:0]   i_cfg_wr_data,
    // input items
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: t_param[16:0], point0[48:17], point1[80:49], point2[112:81],
    //        point3[144:113], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // result items
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: curve_value[31:0], saturated[32], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int VB = (VALUE_WIDTH < POINT_W) ? VALUE_WIDTH : POINT_W;
    localparam int DW = VB + 3;                  // point differences
    localparam int PW = DW + TENSION_W + 1;      // tension products, Q.30
    localparam int CW = PW - 14;                 // coefficients, Q.16
    localparam int RW = VB + 10;                 // Horner accumulator, Q.16
    localparam logic signed [PW-1:0] ROUND14 = PW'(32'd8192);
    localparam logic signed [RW-1:0] SAT_HI  = RW'((64'd1 << (VB - 1)) - 64'd1);
    localparam logic signed [RW-1:0] SAT_LO  = -SAT_HI - RW'(1);
    localparam logic signed [POINT_W-1:0] OUT_HI = POINT_W'($signed(SAT_HI[VB-1:0]));
    localparam logic signed [POINT_W-1:0] OUT_LO = POINT_W'($signed(SAT_LO[VB-1:0]));

    logic [TENSION_W-1:0]  r_tension;

    logic                  pipe_en;

    logic [T_W-1:0]        in_t;
    logic signed [VB-1:0]  in_p0, in_p1, in_p2, in_p3;
    logic signed [DW-1:0]  x0, x1, x2, x3;

    logic                  r_s1_vld;
    logic [T_W-1:0]        r_s1_t;
    logic signed [DW-1:0]  r_s1_d0, r_s1_d1, r_s1_d2, r_s1_e;
    logic signed [VB-1:0]  r_s1_p1;

    logic                  r_s2_vld;
    logic [T_W-1:0]        r_s2_t;
    logic signed [PW-1:0]  r_s2_m0, r_s2_m1, r_s2_m2;
    logic signed [DW-1:0]  r_s2_e;
    logic signed [VB-1:0]  r_s2_p1;

    logic signed [PW-1:0]  e_w, raw0, raw1, raw2;

    logic                  r_s3_vld;
    logic [T_W-1:0]        r_s3_t;
    logic signed [CW-1:0]  r_s3_c0, r_s3_c1, r_s3_c2;
    logic signed [VB-1:0]  r_s3_p1;

    logic signed [CW-1:0]  r_h1a_c2, r_h1b_c2;
    logic signed [VB-1:0]  r_h1a_p1, r_h1b_p1, r_h2a_p1, r_h2b_p1;

    logic                  h1_vld, h2_vld, h3_vld;
    logic signed [RW-1:0]  h1_r, h2_r, h3_r;
    logic [T_W-1:0]        h1_t, h2_t, h3_t;

    logic                  sat_hi, sat_lo;
    logic signed [VB-1:0]  sat_val;
    logic [OUT_FIELDS_W-1:0] res_data;

    logic                  r_out_vld, r_skid_vld;
    logic [OUT_FIELDS_W-1:0] r_out_data, r_skid_data;
    logic                  out_take, incoming;

    // tension register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= TENSION_RESET;
        end else if (i_cfg_wr_en) begin
            r_tension <= i_cfg_wr_data;
        end
    end

    // whole pipeline advances while the skid stage is free
    assign pipe_en    = !r_skid_vld;
    assign o_s_tready = pipe_en;

    // unpack item, low VB bits of each control value
    always_comb begin
        in_t  = i_s_tdata[T_W-1:0];
        in_p0 = $signed(i_s_tdata[T_W +: VB]);
        in_p1 = $signed(i_s_tdata[T_W + POINT_W +: VB]);
        in_p2 = $signed(i_s_tdata[T_W + 2*POINT_W +: VB]);
        in_p3 = $signed(i_s_tdata[T_W + 3*POINT_W +: VB]);
        x0 = DW'(in_p0);
        x1 = DW'(in_p1);
        x2 = DW'(in_p2);
        x3 = DW'(in_p3);
    end

    // stage 1: differences that the tension multiplies
    //   c0 = s*(P3-P0-P1+P2) + 2^15*(P1-P2)
    //   c1 = s*(2P0+P1-2P2-P3) - 3*2^14*(P1-P2)
    //   c2 = s*(P2-P0)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s1_vld <= i_s_tvalid;
        end
        if (pipe_en) begin
            r_s1_t  <= in_t;
            r_s1_d0 <= (x3 - x0) + (x2 - x1);
            r_s1_d1 <= ((x0 <<< 1) + x1) - ((x2 <<< 1) + x3);
            r_s1_d2 <= x2 - x0;
            r_s1_e  <= x1 - x2;
            r_s1_p1 <= in_p1;
        end
    end

    // stage 2: tension products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (pipe_en) begin
            r_s2_t  <= r_s1_t;
            r_s2_m0 <= $signed({1'b0, r_tension}) * r_s1_d0;
            r_s2_m1 <= $signed({1'b0, r_tension}) * r_s1_d1;
            r_s2_m2 <= $signed({1'b0, r_tension}) * r_s1_d2;
            r_s2_e  <= r_s1_e;
            r_s2_p1 <= r_s1_p1;
        end
    end

    // constant terms and rounding from Q.30 to Q.16
    always_comb begin
        e_w  = PW'(r_s2_e);
        raw0 = r_s2_m0 + (e_w <<< 15) + ROUND14;
        raw1 = r_s2_m1 - (e_w <<< 15) - (e_w <<< 14) + ROUND14;
        raw2 = r_s2_m2 + ROUND14;
    end

    // stage 3: coefficients; c3 is P1 itself
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s3_vld <= r_s2_vld;
        end
        if (pipe_en) begin
            r_s3_t  <= r_s2_t;
            r_s3_c0 <= $signed(raw0[PW-1:14]);
            r_s3_c1 <= $signed(raw1[PW-1:14]);
            r_s3_c2 <= $signed(raw2[PW-1:14]);
            r_s3_p1 <= r_s2_p1;
        end
    end

    // coefficients still waiting for their Horner step
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_h1a_c2 <= r_s3_c2;
            r_h1b_c2 <= r_h1a_c2;
            r_h1a_p1 <= r_s3_p1;
            r_h1b_p1 <= r_h1a_p1;
            r_h2a_p1 <= r_h1b_p1;
            r_h2b_p1 <= r_h2a_p1;
        end
    end

    // Horner: r = c0; r = R(r*t)+c1; r = R(r*t)+c2; r = R(r*t)+c3
    csp_horner_step #(.RW(RW)) u_step1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_s3_vld),
        .i_r     (RW'(r_s3_c0)),
        .i_t     (r_s3_t),
        .i_add   (RW'(r_s3_c1)),
        .o_vld   (h1_vld),
        .o_r     (h1_r),
        .o_t     (h1_t)
    );

    csp_horner_step #(.RW(RW)) u_step2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (h1_vld),
        .i_r     (h1_r),
        .i_t     (h1_t),
        .i_add   (RW'(r_h1b_c2)),
        .o_vld   (h2_vld),
        .o_r     (h2_r),
        .o_t     (h2_t)
    );

    csp_horner_step #(.RW(RW)) u_step3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (h2_vld),
        .i_r     (h2_r),
        .i_t     (h2_t),
        .i_add   (RW'(r_h2b_p1)),
        .o_vld   (h3_vld),
        .o_r     (h3_r),
        .o_t     (h3_t)
    );

    // clip to the signed VB-bit range
    always_comb begin
        sat_hi = h3_r > SAT_HI;
        sat_lo = h3_r < SAT_LO;
        if (sat_hi) begin
            sat_val = $signed(SAT_HI[VB-1:0]);
        end else if (sat_lo) begin
            sat_val = $signed(SAT_LO[VB-1:0]);
        end else begin
            sat_val = h3_r[VB-1:0];
        end
        res_data = {sat_hi | sat_lo, POINT_W'(sat_val)};
    end

    // output register with one-item skid stage
    assign out_take = r_out_vld && i_m_tready;
    assign incoming = h3_vld && pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || out_take) begin
            r_out_vld  <= r_skid_vld || incoming;
            r_skid_vld <= 1'b0;
        end else if (incoming) begin
            r_skid_vld <= 1'b1;
        end
        if (!r_out_vld || out_take) begin
            r_out_data <= r_skid_vld ? r_skid_data : res_data;
        end else if (incoming) begin
            r_skid_data <= res_data;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_data);

    // h3_t is the parameter leaving the last step; unused past it
    logic unused_t;
    assign unused_t = ^h3_t;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage full while output register empty");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[POINT_W]) |->
        (o_m_tdata[POINT_W-1:0] == OUT_HI || o_m_tdata[POINT_W-1:0] == OUT_LO))
        else $error("saturated result not at a range limit");

    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_tension == TENSION_RESET && !o_m_tvalid && !r_skid_vld))
        else $error("state after reset wrong");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && $past(i_rst_n)) |=> ($stable(h3_vld) && $stable(h3_r)))
        else $error("pipeline moved while skid stage full");
`endif

endmodule
